>>> sv/rpi_pkg.sv
// Shared types, widths and register codes for the ray/plane intersection core.
`default_nettype none
package rpi_pkg;

    localparam int CW     = 20;           // coordinate width, Q8.12
    localparam int PD_W   = 2 * CW;       // n*t product
    localparam int DIFF_W = CW + 1;       // c - s
    localparam int PN_W   = CW + DIFF_W;  // n*(c-s) product
    localparam int DEN_W  = PD_W + 2;     // sum of three products
    localparam int NUM_W  = PN_W + 2;
    localparam int AN_W   = 41;           // |num|
    localparam int AD_W   = 40;           // |den|
    localparam int D_W    = AD_W + 1;     // divisor 2*|den|
    localparam int N_W    = 63;           // dividend 2*|num|*|t| + |den|
    localparam int QB     = 25;           // quotient bits
    localparam int QLIM_SH = 24;          // offset clamp is 2^24
    localparam int DIVC_W = N_W + 3;      // compare width in a divide step
    localparam int P_W    = 26;           // unsaturated hit coordinate
    localparam int W_W    = P_W + 1;      // hit minus center
    localparam int WN_W   = 22;           // narrowed offset, |w| <= 2^20
    localparam int M_W    = WN_W + CW;    // offset * up product
    localparam int MAG_W  = 42;           // |cross| and |dot|
    localparam int HALF_W = MAG_W / 2;
    localparam int X_W    = 2 * MAG_W + 2;
    localparam int UU_W   = 2 * CW + 1;
    localparam int HS_W   = 2 * (CW - 1);
    localparam int LIM_W  = HS_W + UU_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3 * CW;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FINITE = 3'd4;

    localparam int OQ_DEPTH = 2;

    typedef struct packed {
        logic signed [CW-1:0] ray_start_x;
        logic signed [CW-1:0] ray_start_y;
        logic signed [CW-1:0] ray_start_z;
        logic signed [CW-1:0] ray_dir_x;
        logic signed [CW-1:0] ray_dir_y;
        logic signed [CW-1:0] ray_dir_z;
        logic                 ray_is_segment;
    } t_ray;

    typedef struct packed {
        logic                 hit;
        logic                 is_parallel;
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
        logic signed [CW-1:0] hit_z;
    } t_res;

    // front to back item
    typedef struct packed {
        logic [2:0][CW-1:0]      s;
        logic [2:0][CW-1:0]      t;
        logic signed [DEN_W-1:0] den;
        logic signed [NUM_W-1:0] num;
        logic                    par;
        logic                    seg_ok;
    } t_mid;

    function automatic logic signed [CW-1:0] field(input logic [CFG_DATA_W-1:0] v,
                                                   input logic [1:0] k);
        return $signed(v[k*CW +: CW]);
    endfunction

endpackage
`default_nettype wire

>>> sv/rpi_queue.sv
// Small register FIFO used between front and back and as the result queue.
`default_nettype none
module rpi_queue #(
    parameter int DEPTH = 4,
    parameter type t_data = logic
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_data i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_data      o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_data            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

>>> sv/rpi_front.sv
// Front: dot products n.d and n.(c-s), parallel and segment classification.
`default_nettype none
module rpi_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire rpi_pkg::t_ray                 i_ray,
    input  wire logic [rpi_pkg::CFG_DATA_W-1:0] i_center,
    input  wire logic [rpi_pkg::CFG_DATA_W-1:0] i_normal,
    output logic                               o_mid_valid,
    output rpi_pkg::t_mid                      o_mid,
    input  wire logic                          i_mid_ready
);
    localparam int CW = rpi_pkg::CW;

    logic                               adv;
    logic                               r_f1_vld, r_f2_vld;
    logic signed [rpi_pkg::PD_W-1:0]    r_pd [3];
    logic signed [rpi_pkg::PN_W-1:0]    r_pn [3];
    logic [2:0][CW-1:0]                 r_s, r_t;
    logic                               r_seg;
    rpi_pkg::t_mid                      r_mid;

    logic signed [rpi_pkg::PD_W-1:0]    pd [3];
    logic signed [rpi_pkg::PN_W-1:0]    pn [3];
    logic signed [CW-1:0]               s_in [3];
    logic signed [CW-1:0]               t_in [3];
    rpi_pkg::t_mid                      mid_nx;

    assign adv         = !r_f2_vld || i_mid_ready;
    assign o_in_ready  = adv;
    assign o_mid_valid = r_f2_vld;
    assign o_mid       = r_mid;

    always_comb begin
        logic signed [CW-1:0]                n, c;
        logic signed [rpi_pkg::DIFF_W-1:0]   diff;
        s_in[0] = i_ray.ray_start_x;
        s_in[1] = i_ray.ray_start_y;
        s_in[2] = i_ray.ray_start_z;
        t_in[0] = i_ray.ray_dir_x;
        t_in[1] = i_ray.ray_dir_y;
        t_in[2] = i_ray.ray_dir_z;
        for (int i = 0; i < 3; i++) begin
            n     = rpi_pkg::field(i_normal, 2'(i));
            c     = rpi_pkg::field(i_center, 2'(i));
            diff  = rpi_pkg::DIFF_W'(c) - rpi_pkg::DIFF_W'(s_in[i]);
            pd[i] = rpi_pkg::PD_W'(n) * rpi_pkg::PD_W'(t_in[i]);
            pn[i] = rpi_pkg::PN_W'(n) * rpi_pkg::PN_W'(diff);
        end
    end

    always_comb begin
        logic signed [rpi_pkg::DEN_W-1:0] den;
        logic signed [rpi_pkg::NUM_W-1:0] num;
        den = rpi_pkg::DEN_W'(r_pd[0]) + rpi_pkg::DEN_W'(r_pd[1])
            + rpi_pkg::DEN_W'(r_pd[2]);
        num = rpi_pkg::NUM_W'(r_pn[0]) + rpi_pkg::NUM_W'(r_pn[1])
            + rpi_pkg::NUM_W'(r_pn[2]);
        mid_nx.s   = r_s;
        mid_nx.t   = r_t;
        mid_nx.den = den;
        mid_nx.num = num;
        mid_nx.par = (den == '0);
        // segment: 0 <= num/den <= 1, exact
        if (!r_seg) begin
            mid_nx.seg_ok = 1'b1;
        end else if (den > 0) begin
            mid_nx.seg_ok = (num >= 0) && (num <= rpi_pkg::NUM_W'(den));
        end else begin
            mid_nx.seg_ok = (num <= 0) && (num >= rpi_pkg::NUM_W'(den));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else if (adv) begin
            r_f1_vld <= i_in_valid;
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_pd[i] <= pd[i];
                r_pn[i] <= pn[i];
                r_s[i]  <= s_in[i];
                r_t[i]  <= t_in[i];
            end
            r_seg <= i_ray.ray_is_segment;
            r_mid <= mid_nx;
        end
    end
endmodule
`default_nettype wire

>>> sv/rpi_back.sv
// Back: pipelined divide for the hit point, rectangle test, saturation.
`default_nettype none
module rpi_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_mid_valid,
    output logic                                o_mid_pop,
    input  wire rpi_pkg::t_mid                  i_mid,
    input  wire logic [rpi_pkg::CFG_DATA_W-1:0] i_center,
    input  wire logic [rpi_pkg::CFG_DATA_W-1:0] i_up,
    input  wire logic [2*rpi_pkg::CW-1:0]       i_half,
    input  wire logic                           i_finite,
    output logic                                o_res_valid,
    output rpi_pkg::t_res                       o_res,
    input  wire logic                           i_res_ready
);
    localparam int CW    = rpi_pkg::CW;
    localparam int QB    = rpi_pkg::QB;
    localparam int N_W   = rpi_pkg::N_W;
    localparam int D_W   = rpi_pkg::D_W;
    localparam int AD_W  = rpi_pkg::AD_W;
    localparam int P_W   = rpi_pkg::P_W;
    localparam int W_W   = rpi_pkg::W_W;
    localparam int M_W   = rpi_pkg::M_W;
    localparam int MAG_W = rpi_pkg::MAG_W;
    localparam int HW    = rpi_pkg::HALF_W;
    localparam int X_W   = rpi_pkg::X_W;
    localparam int LIM_W = rpi_pkg::LIM_W;
    localparam int UU_W  = rpi_pkg::UU_W;
    localparam int HS_W  = rpi_pkg::HS_W;
    localparam int DC_W  = rpi_pkg::DIVC_W;
    // stages: product, dividend, QB divide steps, point, six rectangle stages
    localparam int NB    = QB + 9;

    typedef struct packed {
        logic [2:0][CW-1:0]       s;
        logic [2:0]               neg;
        logic                     par;
        logic                     seg_ok;
        logic [2:0][D_W-1:0]      ph;
        logic [2:0][D_W-2:0]      pl;
        logic [AD_W-1:0]          ad;
    } t_b1;

    typedef struct packed {
        logic [2:0][CW-1:0]       s;
        logic [2:0]               neg;
        logic                     par;
        logic                     seg_ok;
        logic [2:0]               ovf;
        logic [D_W-1:0]           d;
        logic [2:0][N_W-1:0]      rem;
        logic [2:0][QB-1:0]       quo;
    } t_dv;

    typedef struct packed {
        logic                     par;
        logic                     seg_ok;
        logic                     far;
        logic [2:0][CW-1:0]       sat;
    } t_rc;

    logic              adv;
    logic [NB-1:0]     r_vld;
    t_b1               r_b1, b1_nx;
    t_dv               r_dv [QB+1];
    t_dv               dv_nx [QB+1];
    logic [2:0][P_W-1:0] r_p, p_nx;
    t_rc               r_rc [6];
    t_rc               rc_nx;
    logic [2:0][rpi_pkg::WN_W-1:0] r_wn;
    logic [2:0][2:0][M_W-1:0]      r_m;
    logic [3:0][MAG_W-1:0]         r_mag;
    logic [3:0][6*HW-1:0]          r_sqp;   // hh, hl, ll per value
    logic [X_W-1:0]    r_x2, r_y2;
    rpi_pkg::t_res     r_out;

    // plane size limits, derived from configuration
    logic [HS_W-1:0]   r_hx2, r_hy2;
    logic [UU_W-1:0]   r_uu;
    logic              r_bad0, r_bad1, r_bad;
    logic [HS_W+CW-1:0] r_lxl, r_lyl;
    logic [HS_W+CW:0]   r_lxh, r_lyh;
    logic [LIM_W-1:0]  r_limx, r_limy;

    assign adv         = !r_vld[NB-1] || i_res_ready;
    assign o_mid_pop   = adv && i_mid_valid;
    assign o_res_valid = adv && r_vld[NB-1];
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NB-2:0], i_mid_valid};
        end
    end

    // size limits: |h|^2 * |up|^2 over three stages
    always_ff @(posedge i_clk) begin
        logic signed [CW-1:0] hx, hy, u;
        logic [UU_W-1:0]      uu;
        hx = $signed(i_half[CW-1:0]);
        hy = $signed(i_half[2*CW-1:CW]);
        uu = '0;
        for (int i = 0; i < 3; i++) begin
            u  = rpi_pkg::field(i_up, 2'(i));
            uu = uu + UU_W'($unsigned((2*CW)'(u) * (2*CW)'(u)));
        end
        r_hx2  <= HS_W'(hx[CW-2:0]) * HS_W'(hx[CW-2:0]);
        r_hy2  <= HS_W'(hy[CW-2:0]) * HS_W'(hy[CW-2:0]);
        r_uu   <= uu;
        r_bad0 <= (hx < 0) || (hy < 0);
        r_lxl  <= (HS_W+CW)'(r_hx2) * (HS_W+CW)'(r_uu[CW-1:0]);
        r_lyl  <= (HS_W+CW)'(r_hy2) * (HS_W+CW)'(r_uu[CW-1:0]);
        r_lxh  <= (HS_W+CW+1)'(r_hx2) * (HS_W+CW+1)'(r_uu[UU_W-1:CW]);
        r_lyh  <= (HS_W+CW+1)'(r_hy2) * (HS_W+CW+1)'(r_uu[UU_W-1:CW]);
        r_bad1 <= r_bad0 || (r_uu == '0);
        r_limx <= (LIM_W'(r_lxh) << CW) + LIM_W'(r_lxl);
        r_limy <= (LIM_W'(r_lyh) << CW) + LIM_W'(r_lyl);
        r_bad  <= r_bad1;
    end

    // stage: magnitudes and |num| * |t| as two partial products per lane
    always_comb begin
        logic [rpi_pkg::NUM_W-1:0] an;
        logic [rpi_pkg::DEN_W-1:0] ad;
        logic signed [CW:0]        ts;
        logic [CW-1:0]             ta;
        an = i_mid.num < 0 ? -i_mid.num : i_mid.num;
        ad = i_mid.den < 0 ? -i_mid.den : i_mid.den;
        b1_nx.s      = i_mid.s;
        b1_nx.par    = i_mid.par;
        b1_nx.seg_ok = i_mid.seg_ok;
        b1_nx.ad     = ad[AD_W-1:0];
        for (int i = 0; i < 3; i++) begin
            ts = (CW+1)'($signed(i_mid.t[i]));
            ta = CW'(ts < 0 ? -ts : ts);
            b1_nx.neg[i] = (i_mid.num < 0) ^ (i_mid.den < 0) ^ (ts < 0);
            b1_nx.ph[i]  = D_W'(an[rpi_pkg::AN_W-1:CW]) * D_W'(ta);
            b1_nx.pl[i]  = (D_W-1)'(an[CW-1:0]) * (D_W-1)'(ta);
        end
    end

    // stage: dividend 2*|num|*|t| + |den|, divisor 2*|den|, overflow check
    always_comb begin
        logic [N_W-2:0] prod;
        logic [N_W-1:0] nn;
        logic [D_W-1:0] d;
        d = {r_b1.ad, 1'b0};
        dv_nx[0].s      = r_b1.s;
        dv_nx[0].neg    = r_b1.neg;
        dv_nx[0].par    = r_b1.par;
        dv_nx[0].seg_ok = r_b1.seg_ok;
        dv_nx[0].d      = d;
        dv_nx[0].quo    = '0;
        for (int i = 0; i < 3; i++) begin
            prod = ((N_W-1)'(r_b1.ph[i]) << CW) + (N_W-1)'(r_b1.pl[i]);
            nn   = {prod, 1'b0} + N_W'(r_b1.ad);
            dv_nx[0].rem[i] = nn;
            dv_nx[0].ovf[i] = DC_W'(nn) >= (DC_W'(d) << QB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1     <= b1_nx;
            r_dv[0]  <= dv_nx[0];
        end
    end

    // one restoring quotient bit per stage
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int K = QB - 1 - j;
        always_comb begin
            logic [DC_W-1:0] sub;
            dv_nx[j+1] = r_dv[j];
            sub = DC_W'(r_dv[j].d) << K;
            for (int i = 0; i < 3; i++) begin
                if (DC_W'(r_dv[j].rem[i]) >= sub) begin
                    dv_nx[j+1].rem[i]    = N_W'(DC_W'(r_dv[j].rem[i]) - sub);
                    dv_nx[j+1].quo[i][K] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv[j+1] <= dv_nx[j+1];
            end
        end
    end

    // stage: clamp the offset, form the point and its saturated copy
    always_comb begin
        logic [QB-1:0]         qc;
        logic signed [P_W-1:0] p;
        rc_nx.par    = r_dv[QB].par;
        rc_nx.seg_ok = r_dv[QB].seg_ok;
        rc_nx.far    = 1'b0;
        for (int i = 0; i < 3; i++) begin
            qc = (r_dv[QB].ovf[i] || r_dv[QB].quo[i] > (QB'(1) << rpi_pkg::QLIM_SH))
               ? (QB'(1) << rpi_pkg::QLIM_SH) : r_dv[QB].quo[i];
            if (r_dv[QB].neg[i]) begin
                p = P_W'($signed(r_dv[QB].s[i])) - $signed(P_W'(qc));
            end else begin
                p = P_W'($signed(r_dv[QB].s[i])) + $signed(P_W'(qc));
            end
            p_nx[i] = p;
            if (p < -(P_W'(1) <<< (CW-1))) begin
                rc_nx.sat[i] = {1'b1, {(CW-1){1'b0}}};
            end else if (p > $signed((P_W'(1) << (CW-1)) - P_W'(1))) begin
                rc_nx.sat[i] = {1'b0, {(CW-1){1'b1}}};
            end else begin
                rc_nx.sat[i] = p[CW-1:0];
            end
        end
    end

    // rectangle pipeline
    always_ff @(posedge i_clk) begin
        logic signed [W_W-1:0]     w;
        logic                      far;
        logic signed [MAG_W:0]     v [4];
        logic signed [M_W-1:0]     m [3][3];
        logic [2*MAG_W-1:0]        sq [4];
        logic [HW-1:0]             mh, ml;
        t_rc                       rc1;
        if (adv) begin
            r_p     <= p_nx;
            r_rc[0] <= rc_nx;
            // offset from center, far check
            far = 1'b0;
            for (int i = 0; i < 3; i++) begin
                w = W_W'($signed(r_p[i])) - W_W'(rpi_pkg::field(i_center, 2'(i)));
                if (w > $signed(W_W'(1) << CW) || w < -(W_W'(1) <<< CW)) begin
                    far = 1'b1;
                end
                r_wn[i] <= w[rpi_pkg::WN_W-1:0];
            end
            rc1     = r_rc[0];
            rc1.far = far;
            r_rc[1] <= rc1;
            // offset * up, all pairs
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_m[i][k] <= M_W'($signed(r_wn[i]))
                               * M_W'(rpi_pkg::field(i_up, 2'(k)));
                end
            end
            r_rc[2] <= r_rc[1];
            // cross product and dot, magnitudes
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    m[i][k] = $signed(r_m[i][k]);
                end
            end
            v[0] = (MAG_W+1)'(m[1][2]) - (MAG_W+1)'(m[2][1]);
            v[1] = (MAG_W+1)'(m[2][0]) - (MAG_W+1)'(m[0][2]);
            v[2] = (MAG_W+1)'(m[0][1]) - (MAG_W+1)'(m[1][0]);
            v[3] = (MAG_W+1)'(m[0][0]) + (MAG_W+1)'(m[1][1]) + (MAG_W+1)'(m[2][2]);
            for (int i = 0; i < 4; i++) begin
                r_mag[i] <= MAG_W'(v[i] < 0 ? -v[i] : v[i]);
            end
            r_rc[3] <= r_rc[2];
            // squares as three half-width partial products
            for (int i = 0; i < 4; i++) begin
                mh = r_mag[i][MAG_W-1:HW];
                ml = r_mag[i][HW-1:0];
                r_sqp[i] <= {(2*HW)'(mh) * (2*HW)'(mh),
                             (2*HW)'(mh) * (2*HW)'(ml),
                             (2*HW)'(ml) * (2*HW)'(ml)};
            end
            r_rc[4] <= r_rc[3];
            // assemble squares, sum
            for (int i = 0; i < 4; i++) begin
                sq[i] = ((2*MAG_W)'(r_sqp[i][6*HW-1:4*HW]) << (2*HW))
                      + ((2*MAG_W)'(r_sqp[i][4*HW-1:2*HW]) << (HW+1))
                      + (2*MAG_W)'(r_sqp[i][2*HW-1:0]);
            end
            r_x2 <= X_W'(sq[0]) + X_W'(sq[1]) + X_W'(sq[2]);
            r_y2 <= X_W'(sq[3]);
            r_rc[5] <= r_rc[4];
            // final compare and result
            r_out.is_parallel <= r_rc[5].par;
            r_out.hit <= !r_rc[5].par && r_rc[5].seg_ok
                      && (!i_finite || (!r_rc[5].far && !r_bad
                                        && r_x2 <= X_W'(r_limx)
                                        && r_y2 <= X_W'(r_limy)));
            r_out.hit_x <= r_rc[5].par ? '0 : $signed(r_rc[5].sat[0]);
            r_out.hit_y <= r_rc[5].par ? '0 : $signed(r_rc[5].sat[1]);
            r_out.hit_z <= r_rc[5].par ? '0 : $signed(r_rc[5].sat[2]);
        end
    end
endmodule
`default_nettype wire

>>> sv/ray_plane_intersect_core.sv
// Top level: ray/plane intersection core with queue-style item channels.
//
// Usage:
//   Input items (t_ray) are offered with push; one is taken at each edge
//   where push is high and full is low. Results (t_res) come out in order:
//   while empty is low the oldest result sits on o_res and is taken at an
//   edge where pop is high. One result per input item.
//   Configuration: i_cfg_valid with i_cfg_index/i_cfg_data writes one plane
//   register (center, normal, up, half size, finite flag); o_cfg_ready is
//   always high. Write only while no item is in flight.
// Timing:
//   From the accepting edge to empty going low an item passes the front
//   stages (dot products, then sums), the middle queue, the 34 back
//   stages and the result queue.
//   The back pipeline length is set by the 25-step restoring divider that
//   forms each hit offset, one quotient bit per stage for all three axes.
//   Throughput is one item per cycle while pop keeps up.
// Stalls and reset:
//   When pop is held low the back stalls in place once the 2-entry result
//   queue fills, then the middle queue fills and full rises. The front and
//   back stall independently. Reset clears all queues and plane registers.
`default_nettype none
module ray_plane_intersect_core #(
    parameter int MQ_DEPTH = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire rpi_pkg::t_ray                     i_ray,
    output logic                                   empty,
    input  wire logic                              pop,
    output rpi_pkg::t_res                          o_res,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rpi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rpi_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int CW = rpi_pkg::CW;

    logic [rpi_pkg::CFG_DATA_W-1:0] r_center, r_normal, r_up;
    logic [2*CW-1:0]                r_half;
    logic                           r_finite;

    logic          in_ready;
    logic          mid_valid, mid_ready, mq_full, mq_empty, mq_pop;
    rpi_pkg::t_mid mid_in, mid_out;
    logic          res_valid, oq_full;
    rpi_pkg::t_res res;

    assign o_cfg_ready = 1'b1;
    assign full        = !in_ready;
    assign mid_ready   = !mq_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_normal <= '0;
            r_up     <= '0;
            r_half   <= '0;
            r_finite <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rpi_pkg::CFG_CENTER: r_center <= i_cfg_data;
                rpi_pkg::CFG_NORMAL: r_normal <= i_cfg_data;
                rpi_pkg::CFG_UP:     r_up     <= i_cfg_data;
                rpi_pkg::CFG_HALF:   r_half   <= i_cfg_data[2*CW-1:0];
                rpi_pkg::CFG_FINITE: r_finite <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    rpi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (push),
        .o_in_ready  (in_ready),
        .i_ray       (i_ray),
        .i_center    (r_center),
        .i_normal    (r_normal),
        .o_mid_valid (mid_valid),
        .o_mid       (mid_in),
        .i_mid_ready (mid_ready)
    );

    rpi_queue #(
        .DEPTH  (MQ_DEPTH),
        .t_data (rpi_pkg::t_mid)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_valid),
        .i_data  (mid_in),
        .o_full  (mq_full),
        .i_pop   (mq_pop),
        .o_empty (mq_empty),
        .o_data  (mid_out)
    );

    rpi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (!mq_empty),
        .o_mid_pop   (mq_pop),
        .i_mid       (mid_out),
        .i_center    (r_center),
        .i_up        (r_up),
        .i_half      (r_half),
        .i_finite    (r_finite),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (!oq_full)
    );

    rpi_queue #(
        .DEPTH  (rpi_pkg::OQ_DEPTH),
        .t_data (rpi_pkg::t_res)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_res)
    );
endmodule
`default_nettype wire

>>> sv/rpi_checker.sv
// Port-level checks for the ray/plane intersection core, bound to the top.
`default_nettype none
module rpi_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          full,
    input wire logic          empty,
    input wire logic          pop,
    input wire rpi_pkg::t_res o_res
);
    // reset drains every queue: the result queue is empty and the input side not full
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    // a parallel ray never hits and reports the origin
    a_parallel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.is_parallel) |->
            (!o_res.hit && o_res.hit_x == '0 && o_res.hit_y == '0 && o_res.hit_z == '0))
        else $error("parallel result with hit or nonzero point");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res)))
        else $error("waiting result changed or dropped");
endmodule

bind ray_plane_intersect_core rpi_checker u_rpi_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_res   (o_res)
);
`default_nettype wire

>>> tb/ray_plane_intersect_core_test.sv
// Self-checking testbench for the ray/plane intersection core.
`timescale 1ns / 100ps
module ray_plane_intersect_core_test;

    localparam int  CLK_HALF   = 5;
    localparam int  DRAIN_CYC  = 60;       // idle wait after the last result
    localparam int  CYCLE_CAP  = 1_500_000;
    localparam int  RAND_ITEMS = 230;      // per plane setting, 8 settings
    localparam longint ONE     = 4096;     // 1.0 in Q8.12

    typedef struct {
        rpi_pkg::t_ray ray;
        bit            typed;   // result written into the row, not predicted
        rpi_pkg::t_res res;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    rpi_pkg::t_ray                  i_ray = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    rpi_pkg::t_res                  o_res;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [rpi_pkg::CFG_IDX_W-1:0]  i_cfg_index = rpi_pkg::CFG_CENTER;
    logic [rpi_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    ray_plane_intersect_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_ray       (i_ray),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Local copy of the plane registers, updated on each accepted write.
    logic [59:0] pl_center = '0;
    logic [59:0] pl_normal = '0;
    logic [59:0] pl_up     = '0;
    logic [39:0] pl_half   = '0;
    logic        pl_finite = 1'b0;

    rpi_pkg::t_res pending_hits[$];   // results owed by the core, oldest first
    int     fail_count = 0;
    int     cycle_count = 0;
    bit     idle_en = 1'b0;    // random gaps and stalls on both sides
    int     pop_hold = 0;

    const rpi_pkg::t_res PARALLEL = '{hit: 1'b0, is_parallel: 1'b1,
                                      hit_x: '0, hit_y: '0, hit_z: '0};

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic longint vec_field(logic [59:0] v, int k);
        logic signed [19:0] f;
        f = v[k*20 +: 20];
        return longint'(f);
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [127:0] sq128(longint v);
        logic [127:0] m;
        m = 128'(mag(v));
        return m * m;
    endfunction

    // Exact rectangle test on squared distances, scaled by |up|^2.
    function automatic bit inside_rect(longint p[3], longint c[3]);
        longint       hx, hy, uu, dot;
        longint       up[3], w[3], cr[3];
        logic [127:0] x2, y2;
        hx = vec_field({20'd0, pl_half}, 0);
        hy = vec_field({20'd0, pl_half}, 1);
        if (hx < 0 || hy < 0) return 1'b0;
        uu = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            up[i] = vec_field(pl_up, i);
            w[i]  = p[i] - c[i];
            // far point: outside every rectangle
            if (mag(w[i]) > (longint'(1) << 20)) return 1'b0;
            uu  += up[i] * up[i];
            dot += w[i] * up[i];
        end
        if (uu == 0) return 1'b0;
        cr[0] = w[1] * up[2] - w[2] * up[1];
        cr[1] = w[2] * up[0] - w[0] * up[2];
        cr[2] = w[0] * up[1] - w[1] * up[0];
        x2 = sq128(cr[0]) + sq128(cr[1]) + sq128(cr[2]);
        y2 = sq128(dot);
        return (x2 <= sq128(hx) * 128'(uu)) && (y2 <= sq128(hy) * 128'(uu));
    endfunction

    function automatic rpi_pkg::t_res ray_hit_point(rpi_pkg::t_ray r);
        longint        s[3], t[3], c[3], n[3], p[3], v[3];
        longint        den, num, an, ad;
        logic [127:0]  q;
        bit            neg, hit;
        rpi_pkg::t_res res;
        s = '{longint'(r.ray_start_x), longint'(r.ray_start_y), longint'(r.ray_start_z)};
        t = '{longint'(r.ray_dir_x), longint'(r.ray_dir_y), longint'(r.ray_dir_z)};
        den = 0;
        num = 0;
        for (int i = 0; i < 3; i++) begin
            c[i] = vec_field(pl_center, i);
            n[i] = vec_field(pl_normal, i);
            den += n[i] * t[i];
            num += n[i] * (c[i] - s[i]);
        end
        if (den == 0) return PARALLEL;
        an = mag(num);
        ad = mag(den);
        for (int i = 0; i < 3; i++) begin
            // offset num*t/den, rounded half away from zero, clamped to 2^24
            q = (128'(2) * 128'(an) * 128'(mag(t[i])) + 128'(ad)) / (128'(2) * 128'(ad));
            if (q > (128'(1) << 24)) q = 128'(1) << 24;
            neg = ((num < 0) != (den < 0)) ^ (t[i] < 0);
            p[i] = neg ? s[i] - longint'(q) : s[i] + longint'(q);
        end
        hit = 1'b1;
        if (r.ray_is_segment) begin
            if (den > 0) hit = (num >= 0) && (num <= den);
            else         hit = (num <= 0) && (num >= den);
        end
        if (hit && pl_finite) hit = inside_rect(p, c);
        for (int i = 0; i < 3; i++) begin
            v[i] = (p[i] < -524288) ? -524288 : ((p[i] > 524287) ? 524287 : p[i]);
        end
        res.hit = hit;
        res.is_parallel = 1'b0;
        res.hit_x = v[0][19:0];
        res.hit_y = v[1][19:0];
        res.hit_z = v[2][19:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 4);
    endfunction

    function automatic rpi_pkg::t_ray mk_ray(longint sx, longint sy, longint sz,
                                             longint dx, longint dy, longint dz,
                                             bit seg);
        rpi_pkg::t_ray r;
        r.ray_start_x = sx[19:0];
        r.ray_start_y = sy[19:0];
        r.ray_start_z = sz[19:0];
        r.ray_dir_x   = dx[19:0];
        r.ray_dir_y   = dy[19:0];
        r.ray_dir_z   = dz[19:0];
        r.ray_is_segment = seg;
        return r;
    endfunction

    function automatic t_stim_row row(rpi_pkg::t_ray r, bit typed = 1'b0,
                                      rpi_pkg::t_res res = '0);
        t_stim_row x;
        x.ray = r;
        x.typed = typed;
        x.res = res;
        return x;
    endfunction

    // Offer one item and hold it until accepted; push stays high afterwards
    // unless a gap follows.
    task automatic feed(rpi_pkg::t_ray r, bit typed = 1'b0, rpi_pkg::t_res res = '0);
        int gap;
        i_ray <= r;
        push  <= 1'b1;
        do @(posedge i_clk); while (full);
        pending_hits.push_back(typed ? res : ray_hit_point(r));
        gap = (idle_en && $urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // All five plane registers, back to back with valid held high.
    task automatic write_plane(logic [59:0] center, logic [59:0] normal,
                               logic [59:0] up, logic [59:0] half, logic [59:0] fin);
        logic [59:0] data;
        for (int k = 0; k < 5; k++) begin
            case (k)
                0: begin i_cfg_index <= rpi_pkg::CFG_CENTER; data = center; end
                1: begin i_cfg_index <= rpi_pkg::CFG_NORMAL; data = normal; end
                2: begin i_cfg_index <= rpi_pkg::CFG_UP;     data = up;     end
                3: begin i_cfg_index <= rpi_pkg::CFG_HALF;   data = half;   end
                default: begin i_cfg_index <= rpi_pkg::CFG_FINITE; data = fin; end
            endcase
            i_cfg_data  <= data;
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
            case (k)
                0: pl_center = data;
                1: pl_normal = data;
                2: pl_up     = data;
                3: pl_half   = data[39:0];   // bits above the two fields ignored
                default: pl_finite = data[0];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [19:0] rand_coord(bit narrow);
        if (narrow) return 20'($urandom_range(0, 32767) - 16384);
        return 20'($urandom());
    endfunction

    // Vector register: unit axis, short random, full random or zero.
    function automatic logic [59:0] rand_vec();
        logic [59:0] v;
        int          ax;
        v = '0;
        case ($urandom_range(0, 7))
            0, 1, 2: begin
                ax = $urandom_range(0, 2);
                v[ax*20 +: 20] = $urandom_range(0, 1) ? 20'(ONE) : 20'(-ONE);
            end
            3, 4: for (int i = 0; i < 3; i++) v[i*20 +: 20] = rand_coord(1'b1);
            5, 6: v = 60'({$urandom(), $urandom()});
            default: v = '0;
        endcase
        return v;
    endfunction

    // Mostly rays aimed at the plane center region, some pure noise.
    function automatic rpi_pkg::t_ray rand_ray();
        longint c, tgt, d, k;
        longint sv[3], dv[3];
        bit     aimed;
        aimed = $urandom_range(0, 9) < 7;
        k = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++) begin
            if (aimed) begin
                c = vec_field(pl_center, i);
                tgt = c + longint'($signed(rand_coord(1'b1)));
                d = longint'($signed(rand_coord(1'b1)));
                sv[i] = tgt - d * k / 2;
                dv[i] = d;
            end else begin
                sv[i] = longint'($signed(rand_coord($urandom_range(0, 1))));
                dv[i] = longint'($signed(rand_coord($urandom_range(0, 1))));
            end
        end
        // now and then a ray lying in the plane direction
        if ($urandom_range(0, 11) == 0) begin
            for (int i = 0; i < 3; i++)
                if (vec_field(pl_normal, i) != 0) dv[i] = 0;
        end
        return mk_ray(sv[0], sv[1], sv[2], dv[0], dv[1], dv[2], $urandom_range(0, 1));
    endfunction

    // ---------------------------------------------------------------
    // Result side: random pop stalls and the checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!idle_en) begin
            pop <= 1'b1;
        end else if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 5) == 0) pop_hold <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        rpi_pkg::t_res want;
        if (i_rst_n && pop && !empty) begin
            if (pending_hits.size() == 0) begin
                $error("unexpected result item: %p", o_res);
                fail_count++;
            end else begin
                want = pending_hits.pop_front();
                if (o_res.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_res.hit);
                    fail_count++;
                end
                if (o_res.is_parallel !== want.is_parallel) begin
                    $error("is_parallel: expected %0d, got %0d",
                           want.is_parallel, o_res.is_parallel);
                    fail_count++;
                end
                if (o_res.hit_x !== want.hit_x) begin
                    $error("hit_x: expected %0d, got %0d", want.hit_x, o_res.hit_x);
                    fail_count++;
                end
                if (o_res.hit_y !== want.hit_y) begin
                    $error("hit_y: expected %0d, got %0d", want.hit_y, o_res.hit_y);
                    fail_count++;
                end
                if (o_res.hit_z !== want.hit_z) begin
                    $error("hit_z: expected %0d, got %0d", want.hit_z, o_res.hit_z);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("ray_plane_intersect_core test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        t_stim_row   reset_rows[$];
        t_stim_row   plane_rows[$];
        logic [59:0] ctr, nrm, upv, hlf, fin;

        // Registers are all zero after reset: zero normal, every ray parallel.
        reset_rows.push_back(row(mk_ray(0, 0, 0, 0, 0, 0, 0), 1, PARALLEL));
        reset_rows.push_back(row(mk_ray(524287, 524287, 524287,
                                        524287, 524287, 524287, 1), 1, PARALLEL));
        reset_rows.push_back(row(mk_ray(-524288, -524288, -524288,
                                        -524288, -524288, -524288, 0), 1, PARALLEL));
        reset_rows.push_back(row(mk_ray(ONE, -ONE, 0, 0, 0, ONE, 1), 1, PARALLEL));

        // Plane z = 1.0, normal +z, up +y, half size 2.0 x 1.0, finite.
        plane_rows.push_back(row(mk_ray(0, 0, 0, 0, 0, 2*ONE, 1)));      // inside, u = 0.5
        plane_rows.push_back(row(mk_ray(0, 0, 0, 0, 0, ONE/2, 1)));      // segment, u = 2
        plane_rows.push_back(row(mk_ray(0, 0, 0, 0, 0, ONE/2, 0)));      // line, u = 2
        plane_rows.push_back(row(mk_ray(0, 0, 0, 0, 0, -ONE, 1)));       // segment, u < 0
        plane_rows.push_back(row(mk_ray(0, 0, 0, 0, 0, -ONE, 0)));       // line, u < 0
        plane_rows.push_back(row(mk_ray(0, 0, 0, 0, 0, ONE, 1)));        // u = 1 exactly
        plane_rows.push_back(row(mk_ray(0, 0, ONE, ONE, 0, ONE, 1)));    // u = 0 exactly
        plane_rows.push_back(row(mk_ray(3*ONE, 0, 0, 0, 0, ONE, 0)));    // beyond half width
        plane_rows.push_back(row(mk_ray(2*ONE, ONE, 0, 0, 0, ONE, 0)));  // on the corner
        plane_rows.push_back(row(mk_ray(0, -2*ONE, 0, 0, 0, ONE, 0)));   // beyond half height
        plane_rows.push_back(row(mk_ray(0, 0, 0, ONE, -ONE, 0, 1), 1, PARALLEL));
        plane_rows.push_back(row(mk_ray(0, 0, 0, 524287, 0, 0, 0), 1, PARALLEL));
        plane_rows.push_back(row(mk_ray(-524288, -524288, -524288,
                                        524287, 524287, 524287, 0)));    // extreme start and direction
        plane_rows.push_back(row(mk_ray(524287, 524287, 524287,
                                        -524288, -524288, -524288, 1)));
        plane_rows.push_back(row(mk_ray(0, 0, 0, 1, 1, 1, 0)));          // unit-LSB direction, hit at 1.0 per axis
        plane_rows.push_back(row(mk_ray(0, 0, 524287, 524287, 0, -1, 0))); // far point
        plane_rows.push_back(row(mk_ray(ONE, ONE/2, -ONE, -ONE/3, 7, ONE/3, 1))); // rounding

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (reset_rows[i]) feed(reset_rows[i].ray, reset_rows[i].typed, reset_rows[i].res);
        drain();

        write_plane({20'(ONE), 20'd0, 20'd0}, {20'(ONE), 20'd0, 20'd0},
                    {20'd0, 20'(ONE), 20'd0}, {20'd0, 20'(ONE), 20'(2*ONE)}, 60'd1);
        foreach (plane_rows[i]) feed(plane_rows[i].ray, plane_rows[i].typed, plane_rows[i].res);
        drain();

        // Random part: one plane setting per round, extremes in the first two.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin   // all ones: every field -1, negative half size
                    ctr = '1; nrm = '1; upv = '1; hlf = '1; fin = '1;
                end
                1: begin   // largest positive fields
                    ctr = {3{20'h7FFFF}}; nrm = {3{20'h7FFFF}}; upv = {3{20'h7FFFF}};
                    hlf = {20'h0, 20'h7FFFF, 20'h7FFFF}; fin = 60'd1;
                end
                default: begin
                    ctr = (ph % 2) ? rand_vec() : 60'({$urandom(), $urandom()});
                    nrm = rand_vec();
                    upv = rand_vec();
                    hlf = 60'({$urandom(), $urandom()});
                    if ($urandom_range(0, 3) != 0) hlf[19] = 1'b0;
                    if ($urandom_range(0, 3) != 0) hlf[39] = 1'b0;
                    fin = 60'({$urandom(), $urandom()});
                    fin[0] = ph % 3 != 2;
                end
            endcase
            // a zero normal makes every ray parallel; keep it out of the random rounds
            if (ph > 1 && nrm == '0) nrm[19:0] = 20'(ONE);
            write_plane(ctr, nrm, upv, hlf, fin);
            idle_en = (ph % 3) != 0;
            for (int i = 0; i < RAND_ITEMS; i++) feed(rand_ray());
            drain();
        end

        if (fail_count == 0) begin
            $display("ray_plane_intersect_core test passed");
        end else begin
            $display("ray_plane_intersect_core test failed");
        end
        $finish;
    end

endmodule
